// ===== rtl/lsh_pkg.sv =====
package lsh_pkg;

  // Element and result word width (signed Q1.15)
  localparam int ElemW = 16;
  // Running sum of squares, unsigned Q10.30
  localparam int SumW = 40;
  // Square of a magnitude: at most 2^(2*(ElemW-1))
  localparam int SqW = 2 * ElemW - 1;
  // Radicand for the root unit, padded to an even bit count
  localparam int RadW = 2 * ElemW;
  // Root digits produced, one per step
  localparam int RootW = ElemW;
  localparam int RootStepsN = RadW / 2;
  localparam int RootCntW = $clog2(RootStepsN);
  // Partial remainder of the root unit
  localparam int RemW = RootW + 3;
  // Configuration data width
  localparam int ModeW = 2;

  // Norm of exactly 1.0 in the sum format
  localparam logic [SumW-1:0] OneSq = SumW'(1) << (2 * (ElemW - 1));
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [RootW-1:0] RootMax = RootW'((1 << (ElemW - 1)) - 1);

  // Augmentation modes
  typedef enum logic [ModeW-1:0] {
    MODE_SYM      = 2'd0,
    MODE_ROOT_ZERO = 2'd1,
    MODE_ZERO_ROOT = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_e;

  // Request to the root unit
  typedef struct packed {
    logic            start;
    logic [RadW-1:0] radicand;
  } lsh_sqrt_req_t;

  // Response from the root unit
  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } lsh_sqrt_rsp_t;

endpackage

// ===== rtl/lsh_if.sv =====
interface lsh_in_if;
  import lsh_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ElemW-1:0] element;
  logic                    last;

  modport source (output valid, output element, output last, input ready);
  modport sink (input valid, input element, input last, output ready);
endinterface

interface lsh_out_if;
  import lsh_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ElemW-1:0] value;
  logic                    last_out;

  modport source (output valid, output value, output last_out, input ready);
  modport sink (input valid, input value, input last_out, output ready);
endinterface

interface lsh_cfg_if;
  import lsh_pkg::*;

  logic             valid;
  logic             ready;
  logic [ModeW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lsh_sqrt.sv =====
module lsh_sqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lsh_pkg::lsh_sqrt_req_t req_i,
  output lsh_pkg::lsh_sqrt_rsp_t rsp_o
);
  import lsh_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [RootCntW-1:0] cnt_q;
  logic [RadW-1:0]     rad_q;
  logic [RemW-1:0]     rem_q;
  logic [RootW-1:0]    root_q;

  logic [RemW-1:0]     rem_shift;
  logic [RemW-1:0]     trial;
  logic                fits;

  // Bring down the next two radicand bits and try the next root digit
  assign rem_shift = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial     = RemW'({root_q, 2'b01});
  assign fits      = (rem_shift >= trial);

  // Restoring root, one digit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rad_q  <= req_i.radicand;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rad_q <= {rad_q[RadW-3:0], 2'b00};
        if (fits) begin
          rem_q  <= rem_shift - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_shift;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == RootCntW'(RootStepsN - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

// ===== rtl/lsh_norm_augment_transform_core.sv =====
// An accepted element is squared, accumulated, then passed on via the output register.
// A new element request is taken only from idle, so one element is in flight at a time.
// A last element then goes through the 16-step root unit (skipped when the norm reaches
// one), and each appended value goes through the output register, which may stall.
// Reset: running sum cleared, mode symmetric, output register empty.
module lsh_norm_augment_transform_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsh_in_if.sink    in_i,
  lsh_out_if.source out_o,
  lsh_cfg_if.sink   cfg_i
);
  import lsh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_PASS,
    S_ROOT,
    S_WAIT,
    S_EMIT1,
    S_EMIT2
  } state_e;

  state_e                  state_q;
  logic [ModeW-1:0]        mode_q;
  logic signed [ElemW-1:0] elem_q;
  logic                    last_q;
  logic [ElemW-1:0]        mag_q;
  logic [SqW-1:0]          sq_q;
  logic [SumW-1:0]         sum_q;
  logic [RootW-1:0]        root_q;
  logic                    out_valid_q;
  logic signed [ElemW-1:0] out_value_q;
  logic                    out_last_q;
  lsh_sqrt_req_t           sqrt_req_q;
  lsh_sqrt_rsp_t           sqrt_rsp;

  logic [ElemW-1:0]        mag_in;
  logic [2*ElemW-1:0]      prod;
  logic [SumW:0]           sum_ext;
  logic                    slot_free;
  logic                    emit_now;
  logic [SumW-1:0]         rad_full;

  // Magnitude of the incoming element, full range of the negative end kept
  assign mag_in    = in_i.element[ElemW-1] ? ElemW'(-in_i.element) : ElemW'(in_i.element);
  assign prod      = mag_q * mag_q;
  assign sum_ext   = {1'b0, sum_q} + (SumW+1)'(sq_q);
  assign rad_full  = OneSq - sum_q;
  assign slot_free = !out_valid_q || out_o.ready;
  assign emit_now  = slot_free &&
                     (state_q == S_PASS || state_q == S_EMIT1 || state_q == S_EMIT2);

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.value    = out_value_q;
  assign out_o.last_out = out_last_q;
  assign cfg_i.ready    = 1'b1;

  // Hold the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SYM;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.data;
    end
  end

  // Sequencer with accumulator and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      elem_q      <= '0;
      last_q      <= 1'b0;
      mag_q       <= '0;
      sq_q        <= '0;
      sum_q       <= '0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
      sqrt_req_q  <= '0;
    end else begin
      // Pulse the root unit start only when a root is needed
      sqrt_req_q.start <= (state_q == S_ROOT) && (sum_q < OneSq);
      // Load or drain the output register
      if (emit_now) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            elem_q  <= in_i.element;
            last_q  <= in_i.last;
            mag_q   <= mag_in;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          sq_q    <= prod[SqW-1:0];
          state_q <= S_ACC;
        end
        S_ACC: begin
          // Saturate the running sum
          sum_q   <= sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
          state_q <= S_PASS;
        end
        S_PASS: begin
          if (slot_free) begin
            out_value_q <= elem_q;
            out_last_q  <= 1'b0;
            state_q     <= last_q ? S_ROOT : S_IDLE;
          end
        end
        S_ROOT: begin
          // A norm of one or more gives a zero root
          if (sum_q >= OneSq) begin
            root_q  <= '0;
            state_q <= S_EMIT1;
          end else begin
            sqrt_req_q.radicand <= rad_full[RadW-1:0];
            state_q             <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (sqrt_rsp.done) begin
            root_q  <= (sqrt_rsp.root > RootMax) ? RootMax : sqrt_rsp.root;
            state_q <= S_EMIT1;
          end
        end
        S_EMIT1: begin
          if (slot_free) begin
            case (mode_q)
              MODE_ROOT_ZERO: begin
                out_value_q <= root_q;
                out_last_q  <= 1'b0;
                state_q     <= S_EMIT2;
              end
              MODE_ZERO_ROOT: begin
                out_value_q <= '0;
                out_last_q  <= 1'b0;
                state_q     <= S_EMIT2;
              end
              default: begin
                out_value_q <= root_q;
                out_last_q  <= 1'b1;
                sum_q       <= '0;
                state_q     <= S_IDLE;
              end
            endcase
          end
        end
        S_EMIT2: begin
          if (slot_free) begin
            out_last_q  <= 1'b1;
            out_value_q <= (mode_q == MODE_ZERO_ROOT) ? root_q : '0;
            sum_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  lsh_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req_q),
    .rsp_o  (sqrt_rsp)
  );

  // The root unit only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_rsp.done |-> state_q == S_WAIT)
    else $error("root unit finished outside the wait state");

  // An appended final value is never negative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_out |-> !out_o.value[ElemW-1])
    else $error("appended root out of range");

  // The running sum is clear once a vector has been closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && ($past(state_q) == S_EMIT1 || $past(state_q) == S_EMIT2)
      |-> sum_q == '0)
    else $error("running sum not cleared after last element");

endmodule
